FILE: rtl/core/refal_pkg.sv
// Shared types and constants for the reference-counting block table allocator.
// Holds the table entry layout, operation and status codes, and the FSM state type.
// No dependencies.
package refal_pkg;

    localparam int unsigned HEAP_MB_W = 12;
    localparam int unsigned MIB_SHIFT = 20;
    localparam int unsigned FREED_W   = 7;

    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_INC     = 2'd1;
    localparam logic [1:0] OP_DEC     = 2'd2;
    localparam logic [1:0] OP_COLLECT = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOMEM    = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    localparam logic [15:0] REF_MAX = 16'hFFFF;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] size;
        logic [31:0] offset;
        logic [15:0] refs;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_SWEEP = 3'b100
    } state_t;

endpackage

FILE: rtl/core/refcount_block_table_allocator.sv
// Reference-counting bump allocator: control, id lookup and collect sweep.
// Instantiates refal_table for the block table; uses refal_pkg.
//
// Usage: one operation per beat on the s_ channel (create, increment, decrement,
// collect), one result beat per operation on the m_ channel. The heap size in
// MiB is written through cfg_wr_en / cfg_wr_data; the user must write it only
// while the block is idle, which the block itself does not enforce. Create needs
// no table read: the end of the last block is kept in a register, and the result
// is registered at the accepting edge. Increment and decrement walk the table one
// entry per cycle through the memory read port and stop at the first matching id.
// Collect reads every entry once and writes the survivors back in order. An
// empty table answers any operation with no table walk; the result is registered
// at the accepting edge.
// The result sits in an output register; s_ready is high when no operation is
// in progress and that register is empty or being taken in the same cycle, so
// a stalled receiver holds the result and blocks the next operation.
// Reset (aresetn low, synchronous) empties the table, zeroes the id counter
// and sets the heap size to 1 MiB. No clearing pass is needed.
module refcount_block_table_allocator
    import refal_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [HEAP_MB_W-1:0] cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_opcode,
    input  logic [31:0]          s_block_size,
    input  logic [31:0]          s_block_id,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [31:0]          m_new_id,
    output logic [31:0]          m_block_offset,
    output logic [FREED_W-1:0]   m_freed_count
);

    localparam int unsigned AW = $clog2(MAX_BLOCKS);
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [31:0]          next_id_reg, next_id_next;
    logic [31:0]          end_reg, end_next;
    logic [HEAP_MB_W-1:0] heap_mb_reg, heap_mb_next;
    logic [CW-1:0]        addr_reg, addr_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        wptr_reg, wptr_next;
    logic [CW-1:0]        freed_reg, freed_next;
    logic [31:0]          id_reg, id_next;
    logic                 dec_reg, dec_next;
    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           m_status_reg, m_status_next;
    logic [31:0]          m_new_id_reg, m_new_id_next;
    logic [31:0]          m_offset_reg, m_offset_next;
    logic [FREED_W-1:0]   m_freed_reg, m_freed_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;

    logic          accept;
    logic          out_free;
    logic [31:0]   limit;
    logic [32:0]   new_end;
    logic          fits;
    logic          last;
    logic          keep;
    logic [CW-1:0] wptr_inc;
    logic [CW-1:0] freed_inc;
    logic [15:0]   refs_mod;

    refal_table #(
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign limit   = {heap_mb_reg, {MIB_SHIFT{1'b0}}};
    assign new_end = {1'b0, end_reg} + {1'b0, s_block_size};
    assign fits    = new_end <= {1'b0, limit};

    assign last      = CW'(pos_reg) == (count_reg - CW'(1));
    assign keep      = rd_data.refs != 16'd0;
    assign wptr_inc  = wptr_reg + CW'(keep);
    assign freed_inc = freed_reg + CW'(!keep);

    always_comb begin
        if (dec_reg) begin
            refs_mod = (rd_data.refs == 16'd0) ? rd_data.refs : rd_data.refs - 16'd1;
        end else begin
            refs_mod = (rd_data.refs == REF_MAX) ? rd_data.refs : rd_data.refs + 16'd1;
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        next_id_next  = next_id_reg;
        end_next      = end_reg;
        heap_mb_next  = cfg_wr_en ? cfg_wr_data : heap_mb_reg;
        addr_next     = addr_reg;
        pend_next     = pend_reg;
        pos_next      = pos_reg;
        wptr_next     = wptr_reg;
        freed_next    = freed_reg;
        id_next       = id_reg;
        dec_next      = dec_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_new_id_next = m_new_id_reg;
        m_offset_next = m_offset_reg;
        m_freed_next  = m_freed_reg;
        wr_en         = 1'b0;
        wr_addr       = pos_reg;
        wr_data       = rd_data;
        rd_en         = 1'b0;
        rd_addr       = addr_reg[AW-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_new_id_next = 32'd0;
                    m_offset_next = 32'd0;
                    m_freed_next  = '0;
                    m_status_next = STAT_OK;
                    id_next       = s_block_id;
                    dec_next      = (s_opcode == OP_DEC);
                    addr_next     = '0;
                    pend_next     = 1'b0;
                    wptr_next     = '0;
                    freed_next    = '0;
                    case (s_opcode)
                        OP_CREATE: begin
                            m_valid_next = 1'b1;
                            if (!fits) begin
                                m_status_next = STAT_NOMEM;
                            end else if (count_reg == CW'(MAX_BLOCKS)) begin
                                m_status_next = STAT_FULL;
                            end else begin
                                m_new_id_next  = next_id_reg;
                                m_offset_next  = end_reg;
                                wr_en          = 1'b1;
                                wr_addr        = count_reg[AW-1:0];
                                wr_data.id     = next_id_reg;
                                wr_data.size   = s_block_size;
                                wr_data.offset = end_reg;
                                wr_data.refs   = 16'd0;
                                count_next     = count_reg + CW'(1);
                                next_id_next   = next_id_reg + 32'd1;
                                end_next       = new_end[31:0];
                            end
                        end
                        OP_INC, OP_DEC: begin
                            if (count_reg == '0) begin
                                m_valid_next  = 1'b1;
                                m_status_next = STAT_NOTFOUND;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            if (count_reg == '0) begin
                                m_valid_next = 1'b1;
                            end else begin
                                end_next   = 32'd0;
                                state_next = ST_SWEEP;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                rd_en     = addr_reg < count_reg;
                pend_next = addr_reg < count_reg;
                pos_next  = addr_reg[AW-1:0];
                if (addr_reg < count_reg) begin
                    addr_next = addr_reg + CW'(1);
                end
                if (pend_reg) begin
                    if (rd_data.id == id_reg) begin
                        wr_en         = 1'b1;
                        wr_addr       = pos_reg;
                        wr_data.refs  = refs_mod;
                        m_valid_next  = 1'b1;
                        m_status_next = STAT_OK;
                        state_next    = ST_IDLE;
                    end else if (last) begin
                        m_valid_next  = 1'b1;
                        m_status_next = STAT_NOTFOUND;
                        state_next    = ST_IDLE;
                    end
                end
            end
            ST_SWEEP: begin
                rd_en     = addr_reg < count_reg;
                pend_next = addr_reg < count_reg;
                pos_next  = addr_reg[AW-1:0];
                if (addr_reg < count_reg) begin
                    addr_next = addr_reg + CW'(1);
                end
                if (pend_reg) begin
                    wptr_next  = wptr_inc;
                    freed_next = freed_inc;
                    if (keep) begin
                        wr_en    = 1'b1;
                        wr_addr  = wptr_reg[AW-1:0];
                        end_next = rd_data.offset + rd_data.size;
                    end
                    if (last) begin
                        count_next    = wptr_inc;
                        m_valid_next  = 1'b1;
                        m_status_next = STAT_OK;
                        m_freed_next  = FREED_W'(freed_inc);
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            next_id_reg <= 32'd0;
            end_reg     <= 32'd0;
            heap_mb_reg <= HEAP_MB_W'(1);
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            next_id_reg <= next_id_next;
            end_reg     <= end_next;
            heap_mb_reg <= heap_mb_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg     <= addr_next;
        pos_reg      <= pos_next;
        wptr_reg     <= wptr_next;
        freed_reg    <= freed_next;
        id_reg       <= id_next;
        dec_reg      <= dec_next;
        m_status_reg <= m_status_next;
        m_new_id_reg <= m_new_id_next;
        m_offset_reg <= m_offset_next;
        m_freed_reg  <= m_freed_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_new_id       = m_new_id_reg;
    assign m_block_offset = m_offset_reg;
    assign m_freed_count  = m_freed_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_BLOCKS))
        else $error("entry count exceeds table depth");

    a_scan_write_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && wr_en) |=> (state_reg == ST_IDLE && m_valid_reg))
        else $error("count update did not end the lookup with a result");

    a_sweep_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP && pend_reg) |-> (wptr_reg <= CW'(pos_reg)))
        else $error("collect write pointer passed the read position");

    a_create_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_opcode == OP_CREATE && fits && count_reg != CW'(MAX_BLOCKS))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("successful create did not grow the table");

endmodule

FILE: rtl/core/refal_table.sv
// Block table storage: one synchronous memory of table entries.
// One write port and one read port with a registered read; uses refal_pkg.
module refal_table
    import refal_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  entry_t                   wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output entry_t                   rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: verif/refcount_block_table_allocator_test.sv
// Self-checking testbench for refcount_block_table_allocator: a directed script, a table
// fill and random phases under several heap sizes, all checked beat by beat.
// Depends on refal_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module refcount_block_table_allocator_test;
    import refal_pkg::*;

    localparam int unsigned MAX_BLOCKS  = 64;
    localparam int          HOLD_CYCLES = 300;
    localparam int          MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        new_id;
        logic [31:0]        offset;
        logic [FREED_W-1:0] freed;
    } alloc_result_t;

    typedef struct {
        bit                   is_cfg;
        logic [HEAP_MB_W-1:0] heap;
        logic [1:0]           op;
        logic [31:0]          size;
        logic [31:0]          id;
        alloc_result_t        want;
    } script_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [HEAP_MB_W-1:0] cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_opcode;
    logic [31:0]          s_block_size;
    logic [31:0]          s_block_id;
    logic                 m_valid;
    logic                 m_ready;
    logic [1:0]           m_status;
    logic [31:0]          m_new_id;
    logic [31:0]          m_block_offset;
    logic [FREED_W-1:0]   m_freed_count;

    entry_t               blocks[$];
    logic [31:0]          id_counter = 32'd0;
    logic [HEAP_MB_W-1:0] heap_mb_q = 12'd1;
    alloc_result_t        pending_results[$];
    script_row_t          script[$];
    int                   mismatch_count = 0;
    bit                   quiet = 1'b0;
    bit                   hold_off = 1'b0;

    refcount_block_table_allocator #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_block_size  (s_block_size),
        .s_block_id    (s_block_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_new_id      (m_new_id),
        .m_block_offset(m_block_offset),
        .m_freed_count (m_freed_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic alloc_result_t table_apply(input logic [1:0] op,
                                                  input logic [31:0] size,
                                                  input logic [31:0] id);
        alloc_result_t r;
        logic [63:0]   tail;
        logic [63:0]   limit;
        entry_t        fresh;
        entry_t        kept[$];
        int            hit;
        r = '0;
        hit = -1;
        case (op)
            OP_CREATE: begin
                tail = 64'd0;
                if (blocks.size() != 0)
                    tail = {32'd0, blocks[$].offset} + {32'd0, blocks[$].size};
                limit = {32'd0, heap_mb_q, {MIB_SHIFT{1'b0}}};
                if (tail + {32'd0, size} > limit) begin
                    r.status = STAT_NOMEM;
                end else if (blocks.size() >= MAX_BLOCKS) begin
                    r.status = STAT_FULL;
                end else begin
                    r.status = STAT_OK;
                    r.new_id = id_counter;
                    r.offset = tail[31:0];
                    fresh.id = id_counter;
                    fresh.size = size;
                    fresh.offset = tail[31:0];
                    fresh.refs = 16'd0;
                    blocks = {blocks, fresh};
                    id_counter = id_counter + 32'd1;
                end
            end
            OP_INC, OP_DEC: begin
                foreach (blocks[i]) begin
                    if (hit < 0 && blocks[i].id == id)
                        hit = i;
                end
                if (hit < 0) begin
                    r.status = STAT_NOTFOUND;
                end else if (op == OP_INC) begin
                    if (blocks[hit].refs != REF_MAX)
                        blocks[hit].refs = blocks[hit].refs + 16'd1;
                end else if (blocks[hit].refs != 16'd0) begin
                    blocks[hit].refs = blocks[hit].refs - 16'd1;
                end
            end
            default: begin
                foreach (blocks[i]) begin
                    if (blocks[i].refs == 16'd0)
                        r.freed = r.freed + 1'b1;
                    else
                        kept = {kept, blocks[i]};
                end
                blocks = kept;
            end
        endcase
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] op, input logic [31:0] size,
                                    input logic [31:0] id, input logic [1:0] status,
                                    input logic [31:0] new_id, input logic [31:0] offset,
                                    input logic [FREED_W-1:0] freed);
        script_row_t row;
        row.is_cfg = 1'b0;
        row.heap = '0;
        row.op = op;
        row.size = size;
        row.id = id;
        row.want.status = status;
        row.want.new_id = new_id;
        row.want.offset = offset;
        row.want.freed = freed;
        script = {script, row};
    endfunction

    function automatic void add_cfg(input logic [HEAP_MB_W-1:0] heap);
        script_row_t row;
        row.is_cfg = 1'b1;
        row.heap = heap;
        row.op = OP_CREATE;
        row.size = '0;
        row.id = '0;
        row.want = '0;
        script = {script, row};
    endfunction

    function automatic void flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic offer(input logic [1:0] op, input logic [31:0] size,
                         input logic [31:0] id, input bit typed, input alloc_result_t want);
        alloc_result_t predicted;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_block_size <= size;
        s_block_id <= id;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = table_apply(op, size, id);
        pending_results = {pending_results, (typed ? want : predicted)};
        @(negedge aclk);
    endtask

    task automatic drain_results(input int settle);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic write_heap(input logic [HEAP_MB_W-1:0] mb);
        drain_results(2);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mb;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        heap_mb_q = mb;
    endtask

    task automatic run_random(input int count);
        logic [1:0]  op;
        logic [31:0] size;
        logic [31:0] id;
        logic [31:0] span;
        int          pick;
        repeat (count) begin
            span = {heap_mb_q, {MIB_SHIFT{1'b0}}} >> 3;
            pick = $urandom_range(0, 99);
            if (pick < 30)
                op = OP_CREATE;
            else if (pick < 60)
                op = OP_INC;
            else if (pick < 85)
                op = OP_DEC;
            else
                op = OP_COLLECT;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                size = $urandom_range(0, span);
            else if (pick < 9)
                size = $urandom_range(0, 255);
            else
                size = $urandom();
            if (blocks.size() != 0 && $urandom_range(0, 99) < 85)
                id = blocks[$urandom_range(0, blocks.size() - 1)].id;
            else
                id = $urandom();
            offer(op, size, id, 1'b0, '0);
        end
    endtask

    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        alloc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                flag_error("result beat with no operation outstanding");
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status)
                    flag_error($sformatf("status expected %0d got %0d",
                                         want.status, m_status));
                if (m_new_id !== want.new_id)
                    flag_error($sformatf("new_id expected %0h got %0h",
                                         want.new_id, m_new_id));
                if (m_block_offset !== want.offset)
                    flag_error($sformatf("block_offset expected %0h got %0h",
                                         want.offset, m_block_offset));
                if (m_freed_count !== want.freed)
                    flag_error($sformatf("freed_count expected %0d got %0d",
                                         want.freed, m_freed_count));
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_opcode = OP_CREATE;
        s_block_size = '0;
        s_block_id = '0;

        add_row(OP_COLLECT, 32'd0, 32'd0, STAT_OK, 32'd0, 32'd0, 7'd0);
        add_row(OP_INC, 32'd0, 32'd0, STAT_NOTFOUND, 32'd0, 32'd0, 7'd0);
        add_row(OP_DEC, 32'd0, 32'hFFFF_FFFF, STAT_NOTFOUND, 32'd0, 32'd0, 7'd0);
        add_row(OP_CREATE, 32'd0, 32'd0, STAT_OK, 32'd0, 32'd0, 7'd0);
        add_row(OP_CREATE, 32'h0010_0000, 32'd0, STAT_OK, 32'd1, 32'd0, 7'd0);
        add_row(OP_CREATE, 32'd1, 32'd0, STAT_NOMEM, 32'd0, 32'd0, 7'd0);
        add_row(OP_CREATE, 32'hFFFF_FFFF, 32'd0, STAT_NOMEM, 32'd0, 32'd0, 7'd0);
        add_row(OP_CREATE, 32'd0, 32'd0, STAT_OK, 32'd2, 32'h0010_0000, 7'd0);
        add_row(OP_INC, 32'd0, 32'd1, STAT_OK, 32'd0, 32'd0, 7'd0);
        add_row(OP_DEC, 32'd0, 32'd1, STAT_OK, 32'd0, 32'd0, 7'd0);
        add_row(OP_DEC, 32'd0, 32'd1, STAT_OK, 32'd0, 32'd0, 7'd0);
        add_row(OP_INC, 32'd0, 32'd2, STAT_OK, 32'd0, 32'd0, 7'd0);
        add_row(OP_INC, 32'd0, 32'hFFFF_FFFF, STAT_NOTFOUND, 32'd0, 32'd0, 7'd0);
        add_row(OP_COLLECT, 32'd0, 32'd0, STAT_OK, 32'd0, 32'd0, 7'd2);
        add_row(OP_CREATE, 32'd0, 32'd0, STAT_OK, 32'd3, 32'h0010_0000, 7'd0);
        add_row(OP_DEC, 32'd0, 32'd2, STAT_OK, 32'd0, 32'd0, 7'd0);
        add_row(OP_COLLECT, 32'd0, 32'd0, STAT_OK, 32'd0, 32'd0, 7'd2);
        add_cfg(12'd0);
        add_row(OP_CREATE, 32'd0, 32'd0, STAT_OK, 32'd4, 32'd0, 7'd0);
        add_row(OP_CREATE, 32'd1, 32'd0, STAT_NOMEM, 32'd0, 32'd0, 7'd0);
        add_cfg(12'd4095);
        add_row(OP_CREATE, 32'hFFF0_0000, 32'd0, STAT_OK, 32'd5, 32'd0, 7'd0);
        add_row(OP_CREATE, 32'd1, 32'd0, STAT_NOMEM, 32'd0, 32'd0, 7'd0);
        add_row(OP_COLLECT, 32'd0, 32'd0, STAT_OK, 32'd0, 32'd0, 7'd2);
        add_row(OP_CREATE, 32'd0, 32'd0, STAT_OK, 32'd6, 32'd0, 7'd0);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_cfg)
                write_heap(script[i].heap);
            else
                offer(script[i].op, script[i].size, script[i].id, 1'b1, script[i].want);
        end

        // Fill the table behind the surviving block, then probe both create failures.
        repeat (MAX_BLOCKS - 1)
            offer(OP_CREATE, $urandom_range(0, 4096), 32'd0, 1'b0, '0);
        offer(OP_CREATE, 32'd0, 32'd0, 1'b0, '0);
        offer(OP_CREATE, 32'hFFFF_FFFF, 32'd0, 1'b0, '0);

        // Raise the first block's count so the collect keeps it and frees the rest.
        repeat (4)
            offer(OP_INC, 32'd0, 32'd6, 1'b0, '0);
        offer(OP_COLLECT, 32'd0, 32'd0, 1'b0, '0);

        write_heap(12'd2);
        hold_off = 1'b1;
        run_random(130);
        write_heap(12'd4095);
        run_random(130);
        write_heap(HEAP_MB_W'($urandom_range(1, 4094)));
        run_random(130);
        write_heap(12'd0);
        run_random(40);
        write_heap(12'd1);
        quiet = 1'b1;
        run_random(80);

        drain_results(MAX_BLOCKS + 4);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
